@@ sv/aoc_pkg.sv @@
// package for the alpha over compositor: pixel types, stage records and constants
package aoc_pkg;

  // full-scale channel value, fully opaque alpha
  localparam logic [7:0] FULL = 8'd255;
  // number of color channels that go through the divider
  localparam int NUM_CHAN = 3;
  // quotient bits, one resolved per divider stage
  localparam int QUOT_BITS = 8;
  // remainder width: 255 * 65025 fits in 24 bits
  localparam int REM_W = 24;
  // weight and denominator width
  localparam int WGT_W = 16;
  // divider stages between the sum stage and the output register
  localparam int DIV_STAGES = QUOT_BITS - 1;

  // one input item: background then foreground pixel
  typedef struct packed {
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic [7:0] bg_alpha;
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] fg_alpha;
  } src_pix_t;

  // one result item: composited pixel
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } dst_pix_t;

  // stage 1: alpha weights and transparency product
  typedef struct packed {
    logic [WGT_W-1:0]             wf;
    logic [WGT_W-1:0]             wb;
    logic [WGT_W-1:0]             trans;
    logic [NUM_CHAN-1:0][7:0]     cf;
    logic [NUM_CHAN-1:0][7:0]     cb;
    logic                         bypass;
    dst_pix_t                     pix;
  } wgt_stage_t;

  // stage 2: per-channel products, denominator and finished alpha
  typedef struct packed {
    logic [NUM_CHAN-1:0][REM_W-1:0] pf;
    logic [NUM_CHAN-1:0][REM_W-1:0] pb;
    logic [WGT_W-1:0]               den;
    logic [7:0]                     alpha;
    logic                           bypass;
    dst_pix_t                       pix;
  } prod_stage_t;

  // divider stages: partial remainders and quotients of the three channels
  typedef struct packed {
    logic [NUM_CHAN-1:0][REM_W-1:0] rem;
    logic [NUM_CHAN-1:0][7:0]       quot;
    logic [WGT_W-1:0]               den;
    logic [7:0]                     alpha;
    logic                           bypass;
    dst_pix_t                       pix;
  } div_stage_t;

endpackage

@@ sv/alpha_over_compositor_top.sv @@
// top level of the alpha over compositor: straight-alpha porter-duff over, fully pipelined
//
//   channel | direction | handshake                 | payload
//   src     | in        | src_valid / src_stall     | src (src_pix_t, bg then fg rgba8)
//   dst     | out       | dst_valid / dst_stall     | dst (dst_pix_t, composited rgba8)
//
// one item enters per clock while no finished item waits on a stalled dst
// stages: weights, products and alpha, channel sums, then seven restoring
// divider stages and the output register, each resolving one quotient bit
// rst is synchronous and clears every stage valid bit; payload is not reset
// a stall on dst while dst_valid is high freezes the whole pipeline and raises src_stall in the same cycle
module alpha_over_compositor_top
  import aoc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  src_pix_t src,
  output logic     dst_valid,
  input  logic     dst_stall,
  output dst_pix_t dst
);

  // one restoring division step on quotient bit k for every channel
  function automatic div_stage_t div_step(input div_stage_t d, input int k);
    div_stage_t               r;
    logic [REM_W:0]           shifted;
    r = d;
    shifted = (REM_W+1)'(d.den) << k;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if ({1'b0, d.rem[c]} >= shifted) begin
        r.rem[c]     = d.rem[c] - shifted[REM_W-1:0];
        r.quot[c][k] = 1'b1;
      end
    end
    return r;
  endfunction

  logic        adv;
  logic        v1;
  logic        v2;
  logic [DIV_STAGES:0] dvv;
  wgt_stage_t  s1;
  wgt_stage_t  s1_next;
  prod_stage_t s2;
  prod_stage_t s2_next;
  div_stage_t  dv [0:DIV_STAGES];
  div_stage_t  dv_next [0:DIV_STAGES];
  div_stage_t  last_step;
  dst_pix_t    dst_next;

  // the whole pipe moves unless a finished item waits on a stalled output
  assign adv       = !(dst_valid && dst_stall);
  assign src_stall = !adv;

  // stage 1: weights wf = af*255, wb = ab*(255-af), transparency product
  always_comb begin
    logic [7:0] naf;
    logic [7:0] nab;
    naf = FULL - src.fg_alpha;
    nab = FULL - src.bg_alpha;
    s1_next.wf    = WGT_W'(src.fg_alpha) * WGT_W'(FULL);
    s1_next.wb    = WGT_W'(src.bg_alpha) * WGT_W'(naf);
    s1_next.trans = WGT_W'(nab) * WGT_W'(naf);
    s1_next.cf    = {src.fg_red, src.fg_green, src.fg_blue};
    s1_next.cb    = {src.bg_red, src.bg_green, src.bg_blue};
    // opaque foreground or both transparent pass a pixel straight through
    s1_next.bypass = (src.fg_alpha == FULL) ||
                     (src.fg_alpha == 8'd0 && src.bg_alpha == 8'd0);
    if (src.fg_alpha == FULL) begin
      s1_next.pix = {src.fg_red, src.fg_green, src.fg_blue, src.fg_alpha};
    end else begin
      s1_next.pix = {src.bg_red, src.bg_green, src.bg_blue, src.bg_alpha};
    end
  end

  // stage 2: color products, denominator, alpha = 255 - ceil(trans/255)
  always_comb begin
    logic [WGT_W-1:0] t;
    logic [WGT_W:0]   qsum;
    for (int c = 0; c < NUM_CHAN; c++) begin
      s2_next.pf[c] = REM_W'(s1.cf[c]) * REM_W'(s1.wf);
      s2_next.pb[c] = REM_W'(s1.cb[c]) * REM_W'(s1.wb);
    end
    s2_next.den = s1.wf + s1.wb;
    // ceil(x/255) = floor((x+254)/255), divide by 255 via x + x/256 + 1 over 256
    t    = s1.trans + WGT_W'(FULL - 8'd1);
    qsum = (WGT_W+1)'(t) + (WGT_W+1)'(t >> 8) + (WGT_W+1)'(1);
    s2_next.alpha  = FULL - qsum[15:8];
    s2_next.bypass = s1.bypass;
    s2_next.pix    = s1.pix;
  end

  // stage 3 sums the products, later stages resolve one quotient bit each
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      dv_next[0].rem[c]  = s2.pf[c] + s2.pb[c];
      dv_next[0].quot[c] = 8'd0;
    end
    dv_next[0].den    = s2.den;
    dv_next[0].alpha  = s2.alpha;
    dv_next[0].bypass = s2.bypass;
    dv_next[0].pix    = s2.pix;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      dv_next[j] = div_step(dv[j-1], QUOT_BITS - j);
    end
  end

  // output: last quotient bit, then choose pass-through or blended pixel
  always_comb begin
    last_step = div_step(dv[DIV_STAGES], 0);
    if (last_step.bypass) begin
      dst_next = last_step.pix;
    end else begin
      dst_next = {last_step.quot[2], last_step.quot[1], last_step.quot[0],
                  last_step.alpha};
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      dvv       <= '0;
      dst_valid <= 1'b0;
    end else if (adv) begin
      v1        <= src_valid;
      v2        <= v1;
      dvv       <= {dvv[DIV_STAGES-1:0], v2};
      dst_valid <= dvv[DIV_STAGES];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1  <= s1_next;
      s2  <= s2_next;
      for (int j = 0; j <= DIV_STAGES; j++) begin
        dv[j] <= dv_next[j];
      end
      dst <= dst_next;
    end
  end

  // a stall freezes every valid bit in the pipe
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, dvv, dst_valid}))
    else $error("pipeline valid bits moved during a stall");

  // blended items always carry a nonzero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (dvv[0] && !dv[0].bypass) |-> (dv[0].den != '0))
    else $error("zero denominator on a blended item");

  // quotient fits in eight bits for every channel
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (dvv[0] && !dv[0].bypass) |->
      ({1'b0, dv[0].rem[0]} < ((REM_W+1)'(dv[0].den) << QUOT_BITS)) &&
      ({1'b0, dv[0].rem[1]} < ((REM_W+1)'(dv[0].den) << QUOT_BITS)) &&
      ({1'b0, dv[0].rem[2]} < ((REM_W+1)'(dv[0].den) << QUOT_BITS)))
    else $error("channel quotient overflows eight bits");

  // before the last step each remainder is below twice the denominator
  a_rem_last: assert property (@(posedge clk) disable iff (rst)
    (dvv[DIV_STAGES] && !dv[DIV_STAGES].bypass) |->
      ({1'b0, dv[DIV_STAGES].rem[0]} < ((REM_W+1)'(dv[DIV_STAGES].den) << 1)) &&
      ({1'b0, dv[DIV_STAGES].rem[1]} < ((REM_W+1)'(dv[DIV_STAGES].den) << 1)) &&
      ({1'b0, dv[DIV_STAGES].rem[2]} < ((REM_W+1)'(dv[DIV_STAGES].den) << 1)))
    else $error("divider remainder out of range before the last bit");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for alpha_over_compositor_top: random and corner pixels checked against a predictor

module tb_top
  import aoc_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RAND_ITEMS = 1150;

  // one pixel pair to send, with the idle cycles that go before it
  typedef struct {
    src_pix_t    pix;
    int unsigned gap;
    bit          wait_empty;
  } feed_item_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  src_pix_t src = '0;
  logic     dst_valid;
  logic     dst_stall = 1'b0;
  dst_pix_t dst;

  feed_item_t  feed_q[$];
  dst_pix_t    expect_q[$];
  dst_pix_t    want;
  int unsigned feed_total = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          gap_loaded = 1'b0;
  bit          src_taken = 1'b0;
  bit          dst_taken = 1'b0;

  alpha_over_compositor_top dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst       (dst)
  );

  always #5 clk = ~clk;

  // straight-alpha over, exact integer form
  function automatic dst_pix_t compose_over(src_pix_t p);
    int unsigned full_w;
    int unsigned af;
    int unsigned ab;
    int unsigned wf;
    int unsigned wb;
    int unsigned den;
    int unsigned trans;
    dst_pix_t    r;
    full_w = FULL;
    af = p.fg_alpha;
    ab = p.bg_alpha;
    if (af == full_w) begin
      r = {p.fg_red, p.fg_green, p.fg_blue, p.fg_alpha};
    end else if (af == 0 && ab == 0) begin
      r = {p.bg_red, p.bg_green, p.bg_blue, p.bg_alpha};
    end else begin
      wf = af * full_w;
      wb = ab * (full_w - af);
      den = wf + wb;
      trans = (full_w - ab) * (full_w - af);
      r.out_red   = 8'((p.fg_red * wf + p.bg_red * wb) / den);
      r.out_green = 8'((p.fg_green * wf + p.bg_green * wb) / den);
      r.out_blue  = 8'((p.fg_blue * wf + p.bg_blue * wb) / den);
      // transparency product rounded up before the complement
      r.out_alpha = 8'(full_w - (trans + full_w - 1) / full_w);
    end
    return r;
  endfunction

  // idle stretches alternate with stretches at full rate
  function automatic int unsigned pick_gap(int unsigned idx);
    if ((idx / 100) % 4 == 1) return 0;
    return $urandom_range(0, 11);
  endfunction

  // alphas lean toward the opaque and transparent ends
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return FULL;
      2: return 8'($urandom_range(1, 3));
      3: return 8'($urandom_range(252, 254));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_pixel(input logic [7:0] br, bgc, bb, ba, fr, fgc, fb, fa,
                             input bit wait_empty);
    feed_item_t it;
    it.pix = {br, bgc, bb, ba, fr, fgc, fb, fa};
    it.gap = pick_gap(feed_total);
    it.wait_empty = wait_empty;
    feed_q.push_back(it);
    feed_total++;
  endtask

  // item driver: holds a stalled item, then idles the drawn gap before the next
  always @(negedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (src_valid && !src_taken) begin
      // hold payload until accepted
    end else begin
      if (!gap_loaded && feed_q.size() != 0) begin
        gap_left = feed_q[0].gap;
        gap_loaded = 1'b1;
      end
      if (feed_q.size() == 0) begin
        src_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        src_valid <= 1'b0;
      end else if (feed_q[0].wait_empty && expect_q.size() != 0) begin
        src_valid <= 1'b0;
      end else begin
        src <= feed_q[0].pix;
        feed_q.delete(0);
        gap_loaded = 1'b0;
        src_valid <= 1'b1;
      end
    end
  end

  // result stall: drawn after each accepted result, with stretches of none
  always @(negedge clk) begin
    if (dst_taken) begin
      n_results++;
      stall_left = ((n_results / 120) % 3 == 2) ? 0 : $urandom_range(0, 11);
    end
    if (stall_left > 0) begin
      dst_stall <= 1'b1;
      stall_left--;
    end else begin
      dst_stall <= 1'b0;
    end
  end

  // monitor: check results against the oldest expectation, record accepted items
  always @(posedge clk) begin
    if (rst) begin
      src_taken <= 1'b0;
      dst_taken <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall) begin
        if (expect_q.size() == 0) begin
          $error("unexpected result item: %h", dst);
          fail_cnt++;
        end else begin
          want = expect_q.pop_front();
          if (dst.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, dst.out_red);
            fail_cnt++;
          end
          if (dst.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, dst.out_green);
            fail_cnt++;
          end
          if (dst.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, dst.out_blue);
            fail_cnt++;
          end
          if (dst.out_alpha !== want.out_alpha) begin
            $error("out_alpha: expected %0d, got %0d", want.out_alpha, dst.out_alpha);
            fail_cnt++;
          end
        end
      end
      if (src_valid && !src_stall) begin
        expect_q.push_back(compose_over(src));
        n_accepted++;
      end
      src_taken <= src_valid && !src_stall;
      dst_taken <= dst_valid && !dst_stall;
    end
  end

  // run timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // corner pixels: extremes, opaque foreground, both transparent, alpha edges
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd90, 8'd180, 8'd45, 8'd77, 8'd12, 8'd200, 8'd77, 8'd255, 1'b0);
    queue_pixel(8'd9, 8'd9, 8'd9, 8'd0, 8'd0, 8'd255, 8'd128, 8'd255, 1'b0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
    queue_pixel(8'd33, 8'd66, 8'd99, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd7, 8'd8, 8'd9, 8'd1, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd200, 8'd254, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd254, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1, 1'b0);
    queue_pixel(8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd128, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd254, 1'b0);
    queue_pixel(8'd10, 8'd20, 8'd30, 8'd255, 8'd250, 8'd240, 8'd230, 8'd128, 1'b0);
    queue_pixel(8'd255, 8'd128, 8'd1, 8'd1, 8'd0, 8'd127, 8'd254, 8'd127, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'haa, 8'h55, 8'hf0, 8'h0f, 8'h55, 8'haa, 8'h0f, 8'hf0, 1'b0);
    queue_pixel(8'h55, 8'haa, 8'h0f, 8'hf0, 8'haa, 8'h55, 8'hf0, 8'h0f, 1'b0);

    // random pixels; a few wait for the pipeline to empty first
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(),
                  8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(),
                  (i % 400) == 0);
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (n_accepted != feed_total) @(negedge clk);
    while (expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
